/* src/spr_pkg.sv */
// Package for the rank correlation block: sizes, class and status codes,
// the critical-value table and the structs shared between the modules.
// Used by the modules in src by scoped names, except spr_ram and spr_queue.
package spr_pkg;

    // Store depth and default sample width.
    localparam int MAX_PAIRS    = 64;
    localparam int SAMPLE_WIDTH = 32;

    // Pair counter and store address widths.
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int ADDR_W = $clog2(MAX_PAIRS);

    // Result field widths.
    localparam int DQ_W  = 19;
    localparam int RHO_W = 16;
    localparam int SE_W  = 16;
    localparam int CLS_W = 3;

    // Arithmetic widths derived from the store depth.
    localparam int SQ_W    = $clog2(MAX_PAIRS * MAX_PAIRS + 1);
    localparam int CUBE_W  = $clog2(MAX_PAIRS * MAX_PAIRS * MAX_PAIRS + 1);
    localparam int DEN_MAX = 2 * (MAX_PAIRS * MAX_PAIRS * MAX_PAIRS - MAX_PAIRS);
    localparam int DEN_W   = $clog2(DEN_MAX + 1);

    // Significance classes.
    localparam logic [CLS_W-1:0] CLS_NONE  = 3'd5;
    localparam logic [CLS_W-1:0] CLS_SMALL = 3'd6;
    localparam logic [CLS_W-1:0] CLS_LARGE = 3'd7;

    // Status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_FEW = 1'b1;

    // Critical |rho| in ten-thousandths for 7..24 pairs, five levels each.
    localparam int CRIT_W      = 14;
    localparam int CRIT_N_LO   = 7;
    localparam int CRIT_N_HI   = 24;
    localparam int CRIT_ROWS   = 18;
    localparam int CRIT_LEVELS = 5;
    localparam int CRIT_ROW_W  = $clog2(CRIT_ROWS);
    localparam int CRIT_LVL_W  = $clog2(CRIT_LEVELS);
    localparam int unsigned CRIT_TAB [CRIT_ROWS][CRIT_LEVELS] = '{
        '{9643, 8571, 7450, 6786, 5357},
        '{9286, 8095, 7143, 6190, 5000},
        '{9000, 7667, 6833, 5833, 4667},
        '{8667, 7333, 6364, 5515, 4424},
        '{8364, 7000, 6091, 5273, 4182},
        '{8182, 6713, 5804, 4965, 3986},
        '{7912, 6429, 5549, 4780, 3791},
        '{7670, 6220, 5341, 4593, 3626},
        '{7464, 6000, 5179, 4429, 3500},
        '{7265, 5824, 5000, 4265, 3382},
        '{7083, 5637, 4853, 4118, 3260},
        '{6904, 5480, 4716, 3994, 3148},
        '{6737, 5333, 4579, 3895, 3070},
        '{6586, 5203, 4451, 3789, 2977},
        '{6455, 5078, 4351, 3688, 2909},
        '{6318, 4963, 4241, 3597, 2829},
        '{6186, 4852, 4150, 3518, 2767},
        '{6070, 4748, 4061, 3435, 2704}
    };

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Write request from the front into the sample stores.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_wr_t;

    // One result item.
    typedef struct packed {
        logic [CNT_W-1:0]        valid_pairs;
        logic [DQ_W-1:0]         sum_sq_rank_diff;
        logic signed [RHO_W-1:0] rho_q15;
        logic [SE_W-1:0]         std_error_q16;
        logic [CLS_W-1:0]        signif_class;
        logic                    status;
    } result_t;

    // Critical value lookup.
    function automatic logic [CRIT_W-1:0] crit_value(
        input logic [CRIT_ROW_W-1:0] row,
        input logic [CRIT_LVL_W-1:0] lvl
    );
        crit_value = CRIT_W'(CRIT_TAB[row][lvl]);
    endfunction

endpackage

/* src/spearman_rank_correlation.sv */
// Spearman rank correlation with averaged ties.
// Input channel s_*: one (x, y) pair per request; a pair with either member
// marked missing is dropped, and at most 64 pairs are kept per set. The
// request with s_is_last set closes the set and yields exactly one result
// request on m_*; other requests yield none.
// Loading: one pair per cycle while s_ready is high. After the last pair
// the stores are locked while the back ranks them: each of the n pairs is
// compared with all n entries through the single read port of each store.
// The front accepts the next set as soon as ranking ends. The rest of the
// result (division, class search, inverse square root search) follows
// after ranking; with fewer than two pairs the back skips ranking and the
// arithmetic and the result goes straight to the output register.
// A result waits in the output register until m_ready; meanwhile the front
// keeps loading the next set and its job waits in the two-entry queue.
// Reset (aresetn low, synchronous) empties the queue, clears the pair
// count and drops any result not yet taken. The stores need no clearing.
// Uses spr_pkg, spr_ram, spr_front, spr_queue and spr_back.
module spearman_rank_correlation #(
    parameter int SAMPLE_WIDTH = spr_pkg::SAMPLE_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_sample_x,
    input  logic signed [SAMPLE_WIDTH-1:0]        s_sample_y,
    input  logic                                  s_x_missing,
    input  logic                                  s_y_missing,
    input  logic                                  s_is_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [spr_pkg::CNT_W-1:0]             m_valid_pairs,
    output logic [spr_pkg::DQ_W-1:0]              m_sum_sq_rank_diff,
    output logic signed [spr_pkg::RHO_W-1:0]      m_rho_q15,
    output logic [spr_pkg::SE_W-1:0]              m_std_error_q16,
    output logic [spr_pkg::CLS_W-1:0]             m_signif_class,
    output logic                                  m_status
);

    spr_pkg::store_wr_t              store_wr;
    logic [SAMPLE_WIDTH-1:0]         wr_x, wr_y, x_rdata, y_rdata;
    logic [spr_pkg::ADDR_W-1:0]      rd_addr;
    logic                            job_push, job_pop, job_valid, queue_full;
    logic                            store_free;
    logic [spr_pkg::CNT_W-1:0]       push_n, job_n;
    spr_pkg::result_t                result;

    // Front: loading and job hand-over.
    spr_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_x  (s_sample_x),
        .s_sample_y  (s_sample_y),
        .s_x_missing (s_x_missing),
        .s_y_missing (s_y_missing),
        .s_is_last   (s_is_last),
        .store_wr    (store_wr),
        .wr_x        (wr_x),
        .wr_y        (wr_y),
        .job_push    (job_push),
        .job_n       (push_n),
        .queue_full  (queue_full),
        .store_free  (store_free)
    );

    // Sample stores.
    spr_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(spr_pkg::MAX_PAIRS)) u_x_store (
        .aclk    (aclk),
        .wr_en   (store_wr.en),
        .wr_addr (store_wr.addr),
        .wr_data (wr_x),
        .rd_addr (rd_addr),
        .rd_data (x_rdata)
    );

    spr_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(spr_pkg::MAX_PAIRS)) u_y_store (
        .aclk    (aclk),
        .wr_en   (store_wr.en),
        .wr_addr (store_wr.addr),
        .wr_data (wr_y),
        .rd_addr (rd_addr),
        .rd_data (y_rdata)
    );

    // Job queue.
    spr_queue #(.WIDTH(spr_pkg::CNT_W), .DEPTH(spr_pkg::QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_n),
        .full      (queue_full),
        .pop       (job_pop),
        .not_empty (job_valid),
        .pop_data  (job_n)
    );

    // Back: ranking and result arithmetic.
    spr_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (job_valid),
        .job_n      (job_n),
        .job_pop    (job_pop),
        .store_free (store_free),
        .rd_addr    (rd_addr),
        .x_rdata    (x_rdata),
        .y_rdata    (y_rdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_valid_pairs      = result.valid_pairs;
    assign m_sum_sq_rank_diff = result.sum_sq_rank_diff;
    assign m_rho_q15          = result.rho_q15;
    assign m_std_error_q16    = result.std_error_q16;
    assign m_signif_class     = result.signif_class;
    assign m_status           = result.status;

endmodule

/* src/spr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/spr_front.sv */
// Front part: accepts sample pairs, drops incomplete ones, writes the stores
// and posts a job with the pair count on the last item. Uses spr_pkg.
module spr_front #(
    parameter int SAMPLE_WIDTH = spr_pkg::SAMPLE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SAMPLE_WIDTH-1:0]       s_sample_x,
    input  logic [SAMPLE_WIDTH-1:0]       s_sample_y,
    input  logic                          s_x_missing,
    input  logic                          s_y_missing,
    input  logic                          s_is_last,
    output spr_pkg::store_wr_t            store_wr,
    output logic [SAMPLE_WIDTH-1:0]       wr_x,
    output logic [SAMPLE_WIDTH-1:0]       wr_y,
    output logic                          job_push,
    output logic [spr_pkg::CNT_W-1:0]     job_n,
    input  logic                          queue_full,
    input  logic                          store_free
);

    logic [spr_pkg::CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic                      hold_reg, hold_next;
    logic                      accept, keep;

    // The stores belong to the back from the last item until it frees them.
    assign s_ready = !hold_reg && !queue_full;
    assign accept  = s_valid && s_ready;
    assign keep    = accept && !s_x_missing && !s_y_missing
                     && (cnt_reg < spr_pkg::CNT_W'(spr_pkg::MAX_PAIRS));
    assign cnt_inc = cnt_reg + spr_pkg::CNT_W'(keep);

    // Store write.
    assign store_wr.en   = keep;
    assign store_wr.addr = cnt_reg[spr_pkg::ADDR_W-1:0];
    assign wr_x          = s_sample_x;
    assign wr_y          = s_sample_y;

    // Job hand-over on the last item.
    assign job_push = accept && s_is_last;
    assign job_n    = cnt_inc;

    always_comb begin
        cnt_next  = job_push ? '0 : cnt_inc;
        hold_next = job_push ? 1'b1 : (store_free ? 1'b0 : hold_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            hold_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            hold_reg <= hold_next;
        end
    end

endmodule

/* src/spr_queue.sv */
// Short job queue between the front and the back.
// Uses no package items.
module spr_queue #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push, do_pop;

    assign full      = (fill_reg == FILL_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers wrap at the depth; the fill level counts pushes less pops.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + FILL_W'(do_push) - FILL_W'(do_pop);
        end
    end

endmodule

/* src/spr_back.sv */
// Back part: ranks both series by sweeping the stores, sums squared rank
// differences, divides for rho, classifies and finds 1/sqrt(n-1).
// Uses spr_pkg; reads the stores held in the top level.
module spr_back #(
    parameter int SAMPLE_WIDTH = spr_pkg::SAMPLE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          job_valid,
    input  logic [spr_pkg::CNT_W-1:0]     job_n,
    output logic                          job_pop,
    output logic                          store_free,
    output logic [spr_pkg::ADDR_W-1:0]    rd_addr,
    input  logic [SAMPLE_WIDTH-1:0]       x_rdata,
    input  logic [SAMPLE_WIDTH-1:0]       y_rdata,
    output logic                          m_valid,
    input  logic                          m_ready,
    output spr_pkg::result_t              result
);

    localparam int CNT_W  = spr_pkg::CNT_W;
    localparam int DEN_W  = spr_pkg::DEN_W;
    localparam int DQ_W   = spr_pkg::DQ_W;
    localparam int RK_W   = CNT_W + 1;
    localparam int NUM_W  = DEN_W + 18;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int LHS_W  = DEN_W + 1 + spr_pkg::CRIT_W;
    localparam int SEK_W  = 17;
    localparam int SEB_W  = $clog2(SEK_W);
    localparam int SQT_W  = 2 * (SEK_W + 1);
    localparam int SEP_W  = CNT_W + SQT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_RDI, S_CAPI, S_SWP, S_ACC, S_MUL1, S_MUL2, S_DEN,
        S_NUM, S_DIVI, S_DIV, S_LHS, S_CLS, S_SEA, S_SEB, S_OUT
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          n_reg, i_reg, j_reg;
    logic [CNT_W-1:0]          gtx_reg, eqx_reg, gty_reg, eqy_reg;
    logic [SAMPLE_WIDTH-1:0]   xi_reg, yi_reg;
    logic [DQ_W-1:0]           dq_reg;
    logic [spr_pkg::SQ_W-1:0]  sq_reg;
    logic [spr_pkg::CUBE_W-1:0] cube_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W:0]            nn_reg, mag_reg;
    logic [NUM_W-1:0]          div_reg;
    logic [DEN_W:0]            rem_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic [LHS_W-1:0]          lhs_reg;
    logic [spr_pkg::CRIT_LVL_W-1:0] k_reg;
    logic [spr_pkg::CLS_W-1:0] cls_reg;
    logic [SEK_W-1:0]          sek_reg;
    logic [SEB_W-1:0]          seb_reg;
    logic [SQT_W-1:0]          sesq_reg;
    logic                      bad_reg;

    logic [RK_W-1:0]           rx, ry;
    logic signed [RK_W:0]      d;
    logic [2*RK_W+1:0]         dsq;
    logic [DEN_W+1:0]          dq_ext, tri3;
    logic signed [DEN_W+1:0]   numr;
    logic [DEN_W+1:0]          trial;
    logic [DEN_W+1:0]          divisor;
    logic [LHS_W-1:0]          rhs;
    logic [spr_pkg::CRIT_ROW_W-1:0] crit_row;
    logic [SEK_W-1:0]          cand;
    logic [SEK_W:0]            tval;
    logic [SEP_W-1:0]          seprod;
    logic [CNT_W-1:0]          m_arg;
    logic                      last_i;

    // Store read address: the pivot entry, then the sweep entries.
    assign rd_addr = (state_reg == S_RDI) ? i_reg[spr_pkg::ADDR_W-1:0]
                                          : j_reg[spr_pkg::ADDR_W-1:0];

    assign job_pop = (state_reg == S_IDLE) && job_valid;
    assign last_i  = (i_reg == n_reg - 1'b1);
    assign store_free = (job_pop && (job_n < CNT_W'(2)))
                        || ((state_reg == S_ACC) && last_i);

    // Doubled ranks with ties averaged and their squared difference.
    assign rx  = {gtx_reg, 1'b0} + RK_W'(eqx_reg) + RK_W'(1);
    assign ry  = {gty_reg, 1'b0} + RK_W'(eqy_reg) + RK_W'(1);
    assign d   = $signed({1'b0, rx}) - $signed({1'b0, ry});
    assign dsq = (2*RK_W+2)'(d) * (2*RK_W+2)'(d);

    // rho numerator: den2 - 3D, and the offset form 2*den2 - 3D.
    assign dq_ext = (DEN_W+2)'(dq_reg);
    assign tri3   = dq_ext + (dq_ext << 1);
    assign numr   = $signed({2'b00, den_reg}) - $signed(tri3);

    // Restoring division step.
    assign divisor = {1'b0, den_reg, 1'b0};
    assign trial   = {rem_reg, div_reg[NUM_W-1]};

    // Critical value test.
    assign crit_row = spr_pkg::CRIT_ROW_W'(n_reg - CNT_W'(spr_pkg::CRIT_N_LO));
    assign rhs = LHS_W'(spr_pkg::crit_value(crit_row, k_reg)) * LHS_W'(den_reg);

    // Inverse square root search: each bit takes an S_SEA and an S_SEB step.
    assign m_arg  = n_reg - 1'b1;
    assign cand   = sek_reg | (SEK_W'(1) << seb_reg);
    assign tval   = {cand, 1'b0} - (SEK_W+1)'(1);
    assign seprod = SEP_W'(m_arg) * SEP_W'(sesq_reg);

    // Result fields.
    always_comb begin
        result.valid_pairs      = n_reg;
        result.sum_sq_rank_diff = bad_reg ? '0 : dq_reg;
        if (bad_reg) begin
            result.rho_q15 = '0;
        end else if (div_reg[16]) begin
            result.rho_q15 = 16'sh7FFF;
        end else begin
            result.rho_q15 = {~div_reg[15], div_reg[14:0]};
        end
        if (bad_reg) begin
            result.std_error_q16 = '0;
        end else if (sek_reg[16]) begin
            result.std_error_q16 = 16'hFFFF;
        end else begin
            result.std_error_q16 = sek_reg[15:0];
        end
        result.signif_class = cls_reg;
        result.status       = bad_reg ? spr_pkg::STATUS_FEW : spr_pkg::STATUS_OK;
    end

    assign m_valid = (state_reg == S_OUT);

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (job_valid) begin
                        n_reg   <= job_n;
                        i_reg   <= '0;
                        dq_reg  <= '0;
                        cls_reg <= spr_pkg::CLS_SMALL;
                        bad_reg <= (job_n < CNT_W'(2));
                        state_reg <= (job_n < CNT_W'(2)) ? S_OUT : S_RDI;
                    end
                end
                S_RDI: begin
                    j_reg     <= '0;
                    state_reg <= S_CAPI;
                end
                S_CAPI: begin
                    xi_reg  <= x_rdata;
                    yi_reg  <= y_rdata;
                    gtx_reg <= '0;
                    eqx_reg <= '0;
                    gty_reg <= '0;
                    eqy_reg <= '0;
                    j_reg   <= CNT_W'(1);
                    state_reg <= S_SWP;
                end
                S_SWP: begin
                    if ($signed(x_rdata) > $signed(xi_reg)) begin
                        gtx_reg <= gtx_reg + 1'b1;
                    end else if (x_rdata == xi_reg) begin
                        eqx_reg <= eqx_reg + 1'b1;
                    end
                    if ($signed(y_rdata) > $signed(yi_reg)) begin
                        gty_reg <= gty_reg + 1'b1;
                    end else if (y_rdata == yi_reg) begin
                        eqy_reg <= eqy_reg + 1'b1;
                    end
                    if (j_reg == n_reg) begin
                        state_reg <= S_ACC;
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                S_ACC: begin
                    dq_reg <= dq_reg + DQ_W'(dsq);
                    i_reg  <= i_reg + 1'b1;
                    state_reg <= last_i ? S_MUL1 : S_RDI;
                end
                S_MUL1: begin
                    sq_reg <= spr_pkg::SQ_W'(spr_pkg::SQ_W'(n_reg) * spr_pkg::SQ_W'(n_reg));
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    cube_reg <= spr_pkg::CUBE_W'(spr_pkg::CUBE_W'(sq_reg)
                                                 * spr_pkg::CUBE_W'(n_reg));
                    state_reg <= S_DEN;
                end
                S_DEN: begin
                    den_reg <= DEN_W'({cube_reg - spr_pkg::CUBE_W'(n_reg), 1'b0});
                    state_reg <= S_NUM;
                end
                S_NUM: begin
                    nn_reg  <= (DEN_W+1)'({1'b0, den_reg, 1'b0} - tri3);
                    mag_reg <= numr[DEN_W+1] ? (DEN_W+1)'(-numr) : (DEN_W+1)'(numr);
                    state_reg <= S_DIVI;
                end
                S_DIVI: begin
                    div_reg  <= NUM_W'({nn_reg, 16'h0000}) + NUM_W'(den_reg);
                    rem_reg  <= '0;
                    dcnt_reg <= DCNT_W'(NUM_W);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (trial >= divisor) begin
                        rem_reg <= (DEN_W+1)'(trial - divisor);
                        div_reg <= {div_reg[NUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial[DEN_W:0];
                        div_reg <= {div_reg[NUM_W-2:0], 1'b0};
                    end
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCNT_W'(1)) begin
                        state_reg <= S_LHS;
                    end
                end
                S_LHS: begin
                    lhs_reg <= LHS_W'(mag_reg) * LHS_W'(10000);
                    k_reg   <= '0;
                    sek_reg <= '0;
                    seb_reg <= SEB_W'(SEK_W - 1);
                    if (n_reg > CNT_W'(spr_pkg::CRIT_N_HI)) begin
                        cls_reg   <= spr_pkg::CLS_LARGE;
                        state_reg <= S_SEA;
                    end else if (n_reg < CNT_W'(spr_pkg::CRIT_N_LO)) begin
                        cls_reg   <= spr_pkg::CLS_SMALL;
                        state_reg <= S_SEA;
                    end else begin
                        state_reg <= S_CLS;
                    end
                end
                S_CLS: begin
                    if (lhs_reg > rhs) begin
                        cls_reg   <= spr_pkg::CLS_W'(k_reg);
                        state_reg <= S_SEA;
                    end else if (k_reg == spr_pkg::CRIT_LVL_W'(spr_pkg::CRIT_LEVELS - 1)) begin
                        cls_reg   <= spr_pkg::CLS_NONE;
                        state_reg <= S_SEA;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_SEA: begin
                    sesq_reg  <= SQT_W'(tval) * SQT_W'(tval);
                    state_reg <= S_SEB;
                end
                S_SEB: begin
                    if (seprod <= (SEP_W'(1) << 34)) begin
                        sek_reg <= cand;
                    end
                    if (seb_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        seb_reg   <= seb_reg - 1'b1;
                        state_reg <= S_SEA;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The sweep never runs past the pair count.
    a_sweep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWP) |-> (j_reg <= n_reg))
        else $error("sweep index beyond pair count");

    // Each pivot is equal to itself, so a finished row has a tie count.
    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC) |-> ((eqx_reg != '0) && (eqy_reg != '0)
                                   && (gtx_reg + eqx_reg <= n_reg)))
        else $error("rank counts out of range");

    // Class 6 is reported exactly for small sets.
    a_small_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((result.signif_class == spr_pkg::CLS_SMALL)
                     == (n_reg < CNT_W'(spr_pkg::CRIT_N_LO))))
        else $error("class does not match pair count");

    // The stores are handed back only while no result is pending.
    a_free_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        store_free |-> !m_valid)
        else $error("stores freed while result pending");

endmodule
